[rtl/core/haar2d_pkg.sv]
package haar2d_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int SUM_W       = 9;
    localparam int COEFF_W     = 10;
    localparam int BAND_W      = 10;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 2048;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET  = 12'd256;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RESET = 12'd256;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        logic signed [SUM_W-1:0] diff;
        logic                    use_line;
        logic [BAND_W-1:0]       band_col;
        logic [BAND_W-1:0]       band_row;
        logic                    frame_done;
    } pair_item_t;

    function automatic int line_depth(input int max_width);
        line_depth = (max_width + 1) >> 1;
    endfunction

    function automatic int addr_w(input int depth);
        addr_w = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int unsigned clamp_size(input logic [CFG_DATA_W-1:0] v,
                                               input int unsigned max_size);
        if (v == '0)
        begin
            clamp_size = 1;
        end
        else if (32'(v) > max_size)
        begin
            clamp_size = max_size;
        end
        else
        begin
            clamp_size = 32'(v);
        end
    endfunction

endpackage

[rtl/core/haar2d_ram.sv]
module haar2d_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [haar2d_pkg::addr_w(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [haar2d_pkg::addr_w(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/haar2d_front.sv]
module haar2d_front #(
    parameter int MAX_WIDTH  = haar2d_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = haar2d_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_write,
    input  logic [haar2d_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [haar2d_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                       accept,
    input  logic [haar2d_pkg::SAMPLE_W-1:0]            sample,
    output haar2d_pkg::pair_item_t                     item,
    output logic                                       item_emit,
    output logic                                       wr_en,
    output logic [haar2d_pkg::addr_w(haar2d_pkg::line_depth(MAX_WIDTH))-1:0] wr_addr,
    output logic [2*haar2d_pkg::SUM_W-1:0]             wr_data,
    output logic                                       rd_en,
    output logic [haar2d_pkg::addr_w(haar2d_pkg::line_depth(MAX_WIDTH))-1:0] rd_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = haar2d_pkg::addr_w(haar2d_pkg::line_depth(MAX_WIDTH));
    localparam int SW = haar2d_pkg::SAMPLE_W;
    localparam int UW = haar2d_pkg::SUM_W;
    localparam int BW = haar2d_pkg::BAND_W;

    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] pend_reg, pend_next;

    logic [31:0]   col_ext;
    logic [31:0]   row_ext;
    logic          last_col;
    logic          last_row;
    logic          pair_ready;
    logic [SW-1:0] pair_a;
    logic [UW-1:0] pair_sum;
    logic [UW-1:0] pair_diff;

    assign col_ext  = 32'(col_reg);
    assign row_ext  = 32'(row_reg);
    assign last_col = (WW'(col_reg) + WW'(1)) == width_reg;
    assign last_row = (HW'(row_reg) + HW'(1)) == height_reg;

    assign pair_ready = col_reg[0] || last_col;
    assign pair_a     = col_reg[0] ? pend_reg : sample;
    assign pair_sum   = {1'b0, pair_a} + {1'b0, sample};
    assign pair_diff  = {1'b0, pair_a} - {1'b0, sample};

    always_comb
    begin
        item.sum        = pair_sum;
        item.diff       = $signed(pair_diff);
        item.use_line   = row_reg[0];
        item.band_col   = col_ext[BW:1];
        item.band_row   = row_ext[BW:1];
        item.frame_done = last_col && last_row;
    end

    assign item_emit = pair_ready && (row_reg[0] || last_row);
    assign wr_en     = accept && pair_ready && !row_reg[0] && !last_row;
    assign wr_addr   = col_ext[AW:1];
    assign wr_data   = {pair_sum, pair_diff};
    assign rd_en     = accept && pair_ready && row_reg[0];
    assign rd_addr   = col_ext[AW:1];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pend_next   = pend_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                haar2d_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_next = WW'(haar2d_pkg::clamp_size(cfg_data, MAX_WIDTH));
                    col_next   = '0;
                    row_next   = '0;
                    pend_next  = '0;
                end
                haar2d_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_next = HW'(haar2d_pkg::clamp_size(cfg_data, MAX_HEIGHT));
                    col_next    = '0;
                    row_next    = '0;
                    pend_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (!col_reg[0] && !last_col)
            begin
                pend_next = sample;
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(haar2d_pkg::clamp_size(haar2d_pkg::IMAGE_WIDTH_RESET,
                                                      MAX_WIDTH));
            height_reg <= HW'(haar2d_pkg::clamp_size(haar2d_pkg::IMAGE_HEIGHT_RESET,
                                                      MAX_HEIGHT));
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

[rtl/core/haar2d_back.sv]
module haar2d_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  haar2d_pkg::pair_item_t                item,
    input  logic                                  item_emit,
    input  logic [2*haar2d_pkg::SUM_W-1:0]        line_data,
    output logic                                  sample_ready,
    output logic                                  coeff_valid,
    input  logic                                  coeff_ready,
    output logic [haar2d_pkg::COEFF_W-1:0]        ll_coeff,
    output logic signed [haar2d_pkg::COEFF_W-1:0] hl_coeff,
    output logic signed [haar2d_pkg::COEFF_W-1:0] lh_coeff,
    output logic signed [haar2d_pkg::COEFF_W-1:0] hh_coeff,
    output logic [haar2d_pkg::BAND_W-1:0]         band_col,
    output logic [haar2d_pkg::BAND_W-1:0]         band_row,
    output logic                                  frame_done
);

    localparam int UW = haar2d_pkg::SUM_W;
    localparam int KW = haar2d_pkg::COEFF_W;
    localparam int BW = haar2d_pkg::BAND_W;

    haar2d_pkg::pair_item_t s1_reg;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   s1_move;

    logic [KW-1:0] sum10, diff10, us10, ud10;
    logic [KW-1:0] ll_reg, hl_reg, lh_reg, hh_reg;
    logic [BW-1:0] col_reg, row_reg;
    logic          done_reg;
    logic [UW-1:0] line_sum;
    logic [UW-1:0] line_diff;

    assign s1_move      = s1_valid_reg && (!out_valid_reg || coeff_ready);
    assign sample_ready = !s1_valid_reg || s1_move;

    assign line_sum  = line_data[2*UW-1:UW];
    assign line_diff = line_data[UW-1:0];

    assign sum10  = {1'b0, s1_reg.sum};
    assign diff10 = {s1_reg.diff[UW-1], s1_reg.diff};
    assign us10   = s1_reg.use_line ? {1'b0, line_sum} : sum10;
    assign ud10   = s1_reg.use_line ? {line_diff[UW-1], line_diff} : diff10;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = item_emit;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (coeff_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= item;
        end
        if (s1_move)
        begin
            ll_reg   <= us10 + sum10;
            hl_reg   <= us10 - sum10;
            lh_reg   <= ud10 + diff10;
            hh_reg   <= ud10 - diff10;
            col_reg  <= s1_reg.band_col;
            row_reg  <= s1_reg.band_row;
            done_reg <= s1_reg.frame_done;
        end
    end

    assign coeff_valid = out_valid_reg;
    assign ll_coeff    = ll_reg;
    assign hl_coeff    = $signed(hl_reg);
    assign lh_coeff    = $signed(lh_reg);
    assign hh_coeff    = $signed(hh_reg);
    assign band_col    = col_reg;
    assign band_row    = row_reg;
    assign frame_done  = done_reg;

endmodule

[rtl/core/haar_2d_forward_stream_top.sv]
// A sample that completes a 2x2 block puts its coefficients through the stage-one
// register and then the output register, loaded only when the output side is free.
// Throughput: one sample per cycle while the output side is not stalled;
// each sample makes at most one line buffer access.
// Reset: counters and pending sample clear, width and height return to 256,
// the line buffer is not cleared; no clearing pass, the block is ready at once.
module haar_2d_forward_stream_top #(
    parameter int MAX_WIDTH  = haar2d_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = haar2d_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [haar2d_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [haar2d_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic [haar2d_pkg::SAMPLE_W-1:0]       sample,
    output logic                                  coeff_valid,
    input  logic                                  coeff_ready,
    output logic [haar2d_pkg::COEFF_W-1:0]        ll_coeff,
    output logic signed [haar2d_pkg::COEFF_W-1:0] hl_coeff,
    output logic signed [haar2d_pkg::COEFF_W-1:0] lh_coeff,
    output logic signed [haar2d_pkg::COEFF_W-1:0] hh_coeff,
    output logic [haar2d_pkg::BAND_W-1:0]         band_col,
    output logic [haar2d_pkg::BAND_W-1:0]         band_row,
    output logic                                  frame_done
);

    localparam int DEPTH = haar2d_pkg::line_depth(MAX_WIDTH);
    localparam int AW    = haar2d_pkg::addr_w(DEPTH);
    localparam int LW    = 2 * haar2d_pkg::SUM_W;

    haar2d_pkg::pair_item_t item;
    logic                   item_emit;
    logic                   accept;
    logic                   wr_en;
    logic                   rd_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [LW-1:0]          wr_data;
    logic [LW-1:0]          line_data;

    assign accept = sample_valid && sample_ready;

    haar2d_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sample    (sample),
        .item      (item),
        .item_emit (item_emit),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    haar2d_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (line_data)
    );

    haar2d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .item_emit    (item_emit),
        .line_data    (line_data),
        .sample_ready (sample_ready),
        .coeff_valid  (coeff_valid),
        .coeff_ready  (coeff_ready),
        .ll_coeff     (ll_coeff),
        .hl_coeff     (hl_coeff),
        .lh_coeff     (lh_coeff),
        .hh_coeff     (hh_coeff),
        .band_col     (band_col),
        .band_row     (band_row),
        .frame_done   (frame_done)
    );

    a_no_write_and_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("line buffer written and read in the same cycle");

    a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (item_emit && item.use_line))
        else $error("line buffer read for a transaction that emits no block");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !item_emit)
        else $error("line buffer write on a transaction that emits a block");

    a_emit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_emit && !coeff_valid) |=> ##1 coeff_valid)
        else $error("emitted block did not reach the output register");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

typedef struct packed {
    logic [haar2d_pkg::COEFF_W-1:0]        ll;
    logic signed [haar2d_pkg::COEFF_W-1:0] hl;
    logic signed [haar2d_pkg::COEFF_W-1:0] lh;
    logic signed [haar2d_pkg::COEFF_W-1:0] hh;
    logic [haar2d_pkg::BAND_W-1:0]         col;
    logic [haar2d_pkg::BAND_W-1:0]         row;
    logic                                  done;
} coeff_blk_t;

typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
} idle_mode_e;

class haar_board;
    localparam int unsigned MAX_W = haar2d_pkg::DEFAULT_MAX_WIDTH;
    localparam int unsigned MAX_H = haar2d_pkg::DEFAULT_MAX_HEIGHT;
    localparam int LINE_ENTRIES = (MAX_W + 1) / 2;

    coeff_blk_t blocks_due[$];
    logic [haar2d_pkg::CFG_DATA_W-1:0] width_reg;
    logic [haar2d_pkg::CFG_DATA_W-1:0] height_reg;
    logic [haar2d_pkg::SAMPLE_W-1:0] held_sample;
    int row_pair_sum[LINE_ENTRIES];
    int row_pair_diff[LINE_ENTRIES];
    int unsigned col_pos;
    int unsigned row_pos;
    int errors;
    int checked;
    int samples;

    function new();
        width_reg = haar2d_pkg::IMAGE_WIDTH_RESET;
        height_reg = haar2d_pkg::IMAGE_HEIGHT_RESET;
        held_sample = '0;
        col_pos = 0;
        row_pos = 0;
        errors = 0;
        checked = 0;
        samples = 0;
        foreach (row_pair_sum[i])
        begin
            row_pair_sum[i] = 0;
            row_pair_diff[i] = 0;
        end
    endfunction

    function int unsigned clamp_dim(logic [haar2d_pkg::CFG_DATA_W-1:0] v, int unsigned top);
        if (v == '0)
            return 1;
        if (int'(v) > top)
            return top;
        return int'(v);
    endfunction

    function void note_config(logic [haar2d_pkg::CFG_INDEX_W-1:0] idx,
                              logic [haar2d_pkg::CFG_DATA_W-1:0] val);
        if (idx == haar2d_pkg::CFG_IMAGE_WIDTH)
            width_reg = val;
        else if (idx == haar2d_pkg::CFG_IMAGE_HEIGHT)
            height_reg = val;
        else
            return;
        col_pos = 0;
        row_pos = 0;
        held_sample = '0;
    endfunction

    function void note_sample(logic [haar2d_pkg::SAMPLE_W-1:0] s);
        int unsigned w;
        int unsigned h;
        int unsigned bx;
        int a;
        int b;
        int pair_sum;
        int pair_diff;
        int up_sum;
        int up_diff;
        bit have_pair;
        bit emit;
        coeff_blk_t blk;
        samples++;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        have_pair = 0;
        a = 0;
        b = 0;
        if (col_pos % 2 == 0)
        begin
            if (col_pos + 1 >= w)
            begin
                a = int'(s);
                b = int'(s);
                have_pair = 1;
            end
            else
            begin
                held_sample = s;
            end
        end
        else
        begin
            a = int'(held_sample);
            b = int'(s);
            have_pair = 1;
        end
        if (have_pair)
        begin
            bx = col_pos >> 1;
            pair_sum = a + b;
            pair_diff = a - b;
            up_sum = 0;
            up_diff = 0;
            emit = 0;
            if (row_pos % 2 == 0)
            begin
                if (row_pos + 1 >= h)
                begin
                    up_sum = pair_sum;
                    up_diff = pair_diff;
                    emit = 1;
                end
                else
                begin
                    row_pair_sum[bx] = pair_sum;
                    row_pair_diff[bx] = pair_diff;
                end
            end
            else
            begin
                up_sum = row_pair_sum[bx];
                up_diff = row_pair_diff[bx];
                emit = 1;
            end
            if (emit)
            begin
                blk.ll = haar2d_pkg::COEFF_W'(up_sum + pair_sum);
                blk.hl = haar2d_pkg::COEFF_W'(up_sum - pair_sum);
                blk.lh = haar2d_pkg::COEFF_W'(up_diff + pair_diff);
                blk.hh = haar2d_pkg::COEFF_W'(up_diff - pair_diff);
                blk.col = haar2d_pkg::BAND_W'(bx);
                blk.row = haar2d_pkg::BAND_W'(row_pos >> 1);
                blk.done = (col_pos + 1 >= w) && (row_pos + 1 >= h);
                blocks_due.insert(blocks_due.size(), blk);
            end
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function void check_coeff(coeff_blk_t got);
        coeff_blk_t want;
        if (blocks_due.size() == 0)
        begin
            $error("coefficient transaction with no block due: ll_coeff %0d", got.ll);
            errors++;
            return;
        end
        want = blocks_due.pop_front();
        checked++;
        if (got.ll !== want.ll)
        begin
            $error("ll_coeff: expected %0d, actual %0d", want.ll, got.ll);
            errors++;
        end
        if (got.hl !== want.hl)
        begin
            $error("hl_coeff: expected %0d, actual %0d", want.hl, got.hl);
            errors++;
        end
        if (got.lh !== want.lh)
        begin
            $error("lh_coeff: expected %0d, actual %0d", want.lh, got.lh);
            errors++;
        end
        if (got.hh !== want.hh)
        begin
            $error("hh_coeff: expected %0d, actual %0d", want.hh, got.hh);
            errors++;
        end
        if (got.col !== want.col)
        begin
            $error("band_col: expected %0d, actual %0d", want.col, got.col);
            errors++;
        end
        if (got.row !== want.row)
        begin
            $error("band_row: expected %0d, actual %0d", want.row, got.row);
            errors++;
        end
        if (got.done !== want.done)
        begin
            $error("frame_done: expected %0d, actual %0d", want.done, got.done);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [haar2d_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [haar2d_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [haar2d_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [haar2d_pkg::CFG_DATA_W-1:0] cfg_data;
    logic sample_valid;
    logic sample_ready;
    logic [haar2d_pkg::SAMPLE_W-1:0] sample;
    logic coeff_valid;
    logic coeff_ready;
    logic [haar2d_pkg::COEFF_W-1:0] ll_coeff;
    logic signed [haar2d_pkg::COEFF_W-1:0] hl_coeff;
    logic signed [haar2d_pkg::COEFF_W-1:0] lh_coeff;
    logic signed [haar2d_pkg::COEFF_W-1:0] hh_coeff;
    logic [haar2d_pkg::BAND_W-1:0] band_col;
    logic [haar2d_pkg::BAND_W-1:0] band_row;
    logic frame_done;

    haar_board sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;
    int phases;

    haar_2d_forward_stream_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .coeff_valid(coeff_valid),
        .coeff_ready(coeff_ready),
        .ll_coeff(ll_coeff),
        .hl_coeff(hl_coeff),
        .lh_coeff(lh_coeff),
        .hh_coeff(hh_coeff),
        .band_col(band_col),
        .band_row(band_row),
        .frame_done(frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [haar2d_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return haar2d_pkg::SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic set_idle(idle_mode_e mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND:
            begin
                send_idle_pct = 64;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 64;
            end
            default:
            begin
                send_idle_pct = 38;
                recv_stall_pct = 38;
            end
        endcase
    endtask

    task automatic write_reg(logic [haar2d_pkg::CFG_INDEX_W-1:0] idx,
                             logic [haar2d_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.note_config(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(logic [haar2d_pkg::SAMPLE_W-1:0] s);
        while (coin(send_idle_pct))
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        sb.note_sample(s);
    endtask

    task automatic send_values(logic [haar2d_pkg::SAMPLE_W-1:0] vals[$]);
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    task automatic send_random(int n);
        repeat (n)
            send_sample(pick_sample());
    endtask

    // drop valid, then hold until every block is out and the pipe is quiet
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.blocks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        phases++;
    endtask

    initial
    begin
        coeff_blk_t got;
        coeff_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (coeff_valid && coeff_ready)
            begin
                got.ll = ll_coeff;
                got.hl = hl_coeff;
                got.lh = lh_coeff;
                got.hh = hh_coeff;
                got.col = band_col;
                got.row = band_row;
                got.done = frame_done;
                sb.check_coeff(got);
            end
            coeff_ready <= !coin(recv_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** haar_2d_forward_stream_top: FAILED **");
        $finish;
    end

    initial
    begin
        logic [haar2d_pkg::SAMPLE_W-1:0] vals[$];
        int random_sent;
        int w_eff;
        int h_eff;
        int n;
        logic [haar2d_pkg::CFG_DATA_W-1:0] w_val;
        logic [haar2d_pkg::CFG_DATA_W-1:0] h_val;
        sb = new();
        phases = 0;
        random_sent = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_valid = 1'b0;
        sample = '0;
        set_idle(IDLE_NONE);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // partial row, then restart it with a rewrite of the same width
        write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, 12'd4);
        write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, 12'd2);
        vals = '{8'd7, 8'd9, 8'd11};
        send_values(vals);
        drain();
        write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, 12'd4);

        // HL extremes; spare indexes written mid-frame must not restart it
        vals = '{8'd255, 8'd255, 8'd0, 8'd0};
        send_values(vals);
        drain();
        write_reg(CFG_SPARE_LO, haar2d_pkg::CFG_DATA_W'($urandom_range(0, 4095)));
        write_reg(CFG_SPARE_HI, 12'hFFF);
        vals = '{8'd0, 8'd0, 8'd255, 8'd255};
        send_values(vals);
        // LH extremes, then HH extremes
        vals = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255};
        send_values(vals);
        vals = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
        send_values(vals);
        drain();

        // odd width and odd height: LL at its top and bottom
        write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, 12'd1);
        vals = '{8'd255, 8'd255, 8'd0};
        send_values(vals);
        drain();

        // zero size acts as one
        write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, 12'd0);
        write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, 12'd0);
        vals = '{8'd200, 8'd1};
        send_values(vals);
        drain();

        // oversize and maximum sizes, short bursts from the frame start
        set_idle(IDLE_BOTH);
        write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, 12'd4095);
        write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, 12'd1);
        send_random(96);
        drain();
        set_idle(IDLE_RECV);
        write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, 12'd2);
        write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, 12'd4095);
        send_random(96);
        drain();
        set_idle(IDLE_SEND);
        write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, 12'd2048);
        write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, 12'd2);
        send_random(64);
        drain();

        while (random_sent < RANDOM_ITEMS)
        begin
            set_idle(idle_mode_e'(phases % 4));
            case ($urandom_range(0, 19))
                0: w_val = '0;
                1: w_val = haar2d_pkg::CFG_DATA_W'($urandom_range(13, 64));
                default: w_val = haar2d_pkg::CFG_DATA_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 19))
                0: h_val = '0;
                1: h_val = haar2d_pkg::CFG_DATA_W'($urandom_range(9, 16));
                default: h_val = haar2d_pkg::CFG_DATA_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0: ;
                1: write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, w_val);
                2: write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, h_val);
                3, 4:
                begin
                    write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, h_val);
                    write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, w_val);
                end
                default:
                begin
                    write_reg(haar2d_pkg::CFG_IMAGE_WIDTH, w_val);
                    write_reg(haar2d_pkg::CFG_IMAGE_HEIGHT, h_val);
                end
            endcase
            if (coin(15))
                write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          haar2d_pkg::CFG_DATA_W'($urandom_range(0, 4095)));
            w_eff = sb.clamp_dim(sb.width_reg, haar2d_pkg::DEFAULT_MAX_WIDTH);
            h_eff = sb.clamp_dim(sb.height_reg, haar2d_pkg::DEFAULT_MAX_HEIGHT);
            n = w_eff * h_eff * $urandom_range(1, 3);
            if (coin(25))
                n = $urandom_range(1, n);
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;
            send_random(n);
            random_sent += n;
            drain();
        end

        $display("Sent %0d samples in %0d phases and checked %0d coefficient blocks,",
                 sb.samples, phases, sb.checked);
        $display("over sizes from 0 to 4095 and four idle and stall profiles.");
        if (sb.errors == 0)
        begin
            $display("** haar_2d_forward_stream_top: PASSED **");
        end
        else
        begin
            $display("** haar_2d_forward_stream_top: FAILED **");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/haar2d_pkg.sv
rtl/core/haar2d_ram.sv
rtl/core/haar2d_front.sv
rtl/core/haar2d_back.sv
rtl/core/haar_2d_forward_stream_top.sv
tb/sv/testbench.sv
